>>> hdl/tensor_index_converter_assert.svh
// ----------------------------------------------------------------------------
// Tensor index converter assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef TENSOR_INDEX_CONVERTER_ASSERT_SVH
`define TENSOR_INDEX_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TIC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TIC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/tic_pkg.sv
// ----------------------------------------------------------------------------
// Tensor index converter package
// Shared constants, codes and the pipeline control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package tic_pkg;

  // Fixed geometry of the block.
  localparam int MAX_RANK     = 4;
  localparam int DIM_BITS_DEF = 12;
  localparam int LIN_BITS     = 48;
  localparam int RANK_BITS    = 3;
  localparam int RW           = 4;   // width of a clamped rank, holds MAX_RANK
  localparam int CFG_IDX_BITS = 3;
  localparam int STEPS        = 4;   // restoring division steps per stage
  localparam int SPD          = LIN_BITS / STEPS;  // stages per dimension
  localparam int NS           = MAX_RANK * SPD;    // divider stages

  // Request kinds.
  localparam logic REQ_SPLIT  = 1'b0;
  localparam logic REQ_OFFSET = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_RANK = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM0 = 3'd1;

  // Result error codes.
  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DIM = 2'd1,
    ERR_RANK     = 2'd2
  } err_t;

  // Control that travels with each beat down the pipeline.
  typedef struct packed {
    logic vld;
    logic req;
    err_t err;
  } ctl_t;

endpackage

`default_nettype wire

>>> hdl/tic_div_stage.sv
// ----------------------------------------------------------------------------
// Tensor index converter pipeline stage
// Four restoring division steps on the running quotient, plus one Horner
// multiply-add step for the offset path in the first stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_div_stage
  import tic_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF,
  parameter int DIV_DIM  = 0,
  parameter bit FIRST    = 1'b0,
  parameter bit LAST     = 1'b0,
  parameter bit H_EN     = 1'b0,
  parameter int H_DIM    = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire ctl_t                         ctl_i,
  input  wire logic [LIN_BITS-1:0]          q_i,
  input  wire logic [DIM_BITS-1:0]          rem_i,
  input  wire logic [LIN_BITS-1:0]          acc_i,
  input  wire logic [MAX_RANK*DIM_BITS-1:0] crd_i,
  input  wire logic [MAX_RANK*DIM_BITS-1:0] idx_i,
  input  wire logic [DIM_BITS-1:0]          div_i,
  input  wire logic [DIM_BITS-1:0]          hsize_i,
  input  wire logic                         hact_i,
  output ctl_t                              ctl_o,
  output logic [LIN_BITS-1:0]               q_o,
  output logic [DIM_BITS-1:0]               rem_o,
  output logic [LIN_BITS-1:0]               acc_o,
  output logic [MAX_RANK*DIM_BITS-1:0]      crd_o,
  output logic [MAX_RANK*DIM_BITS-1:0]      idx_o
);

  ctl_t                          ctl_r;
  logic [LIN_BITS-1:0]           q_r, q_nxt;
  logic [DIM_BITS-1:0]           rem_r, rem_nxt;
  logic [LIN_BITS-1:0]           acc_r, acc_nxt;
  logic [MAX_RANK*DIM_BITS-1:0]  crd_r, crd_nxt;
  logic [MAX_RANK*DIM_BITS-1:0]  idx_r;
  logic [LIN_BITS+DIM_BITS-1:0]  prod;

  // Restoring division: shift one dividend bit into the remainder per step.
  always_comb begin
    logic [DIM_BITS:0] sh;
    rem_nxt = FIRST ? '0 : rem_i;
    q_nxt   = q_i;
    sh      = '0;
    for (int i = 0; i < STEPS; i++) begin
      sh    = {rem_nxt, q_nxt[LIN_BITS-1]};
      q_nxt = {q_nxt[LIN_BITS-2:0], 1'b0};
      if (sh >= {1'b0, div_i}) begin
        sh       = sh - {1'b0, div_i};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = sh[DIM_BITS-1:0];
    end
    crd_nxt = crd_i;
    if (LAST) begin
      crd_nxt[DIV_DIM*DIM_BITS +: DIM_BITS] = rem_nxt;
    end
  end

  // Horner step of the offset: acc * size + aligned index.
  always_comb begin
    prod    = acc_i * hsize_i;
    acc_nxt = acc_i;
    if (H_EN && hact_i) begin
      acc_nxt = prod[LIN_BITS-1:0] + LIN_BITS'(idx_i[H_DIM*DIM_BITS +: DIM_BITS]);
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      crd_r <= crd_nxt;
      idx_r <= idx_i;
    end
  end

  assign ctl_o = ctl_r;
  assign q_o   = q_r;
  assign rem_o = rem_r;
  assign acc_o = acc_r;
  assign crd_o = crd_r;
  assign idx_o = idx_r;

endmodule

`default_nettype wire

>>> hdl/tensor_index_converter.sv
// ----------------------------------------------------------------------------
// Tensor index converter
// Row-major index unit: splits a linear index into coordinates or maps
// right-aligned, broadcast-aware coordinates to a flat offset.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | content
//  in_        | input     | in_valid/in_stall   | request type, index, coordinates
//  out_       | output    | out_valid/out_stall | offset, coordinates, error code
//  cfg_       | input     | cfg_we              | rank and dimension sizes
//
// One beat enters per cycle unless the output stalls; results pass an entry
// register and 48 divider stages of four quotient bits, 12 per dimension.
// The offset path uses one multiply-add per dimension in the first stages.
// Reset clears all valid bits, rank to 0 and every size to 1.
// When the output beat is stalled the whole pipeline holds and in_stall rises.
`default_nettype none

module tensor_index_converter
  import tic_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF,
  localparam int CfgW = (DIM_BITS > RANK_BITS) ? DIM_BITS : RANK_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CfgW-1:0]         cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_req_type,
  input  wire logic [LIN_BITS-1:0]     in_linear_index,
  input  wire logic [RANK_BITS-1:0]    in_target_rank,
  input  wire logic [DIM_BITS-1:0]     in_index_0,
  input  wire logic [DIM_BITS-1:0]     in_index_1,
  input  wire logic [DIM_BITS-1:0]     in_index_2,
  input  wire logic [DIM_BITS-1:0]     in_index_3,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [LIN_BITS-1:0]          out_linear_offset,
  output logic [DIM_BITS-1:0]          out_coord_0,
  output logic [DIM_BITS-1:0]          out_coord_1,
  output logic [DIM_BITS-1:0]          out_coord_2,
  output logic [DIM_BITS-1:0]          out_coord_3,
  output logic [1:0]                   out_error_code
);

  `include "tensor_index_converter_assert.svh"

  logic [RANK_BITS-1:0]          rank_r;
  logic [DIM_BITS-1:0]           size_r [MAX_RANK];
  logic [RW-1:0]                 rank_eff, tr_eff;
  logic [DIM_BITS-1:0]           idx_in [MAX_RANK];
  logic                          en;

  ctl_t                          ctl_nxt;
  logic [MAX_RANK*DIM_BITS-1:0]  idx_al;

  ctl_t                          ctl_s [NS+1];
  logic [LIN_BITS-1:0]           q_s   [NS+1];
  logic [DIM_BITS-1:0]           rem_s [NS+1];
  logic [LIN_BITS-1:0]           acc_s [NS+1];
  logic [MAX_RANK*DIM_BITS-1:0]  crd_s [NS+1];
  logic [MAX_RANK*DIM_BITS-1:0]  idx_s [NS+1];

  logic                          crd_ok;

  assign idx_in[0] = in_index_0;
  assign idx_in[1] = in_index_1;
  assign idx_in[2] = in_index_2;
  assign idx_in[3] = in_index_3;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
      for (int d = 0; d < MAX_RANK; d++) begin
        size_r[d] <= DIM_BITS'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_RANK) begin
        rank_r <= cfg_data[RANK_BITS-1:0];
      end
      for (int d = 0; d < MAX_RANK; d++) begin
        if (cfg_index == CFG_DIM0 + CFG_IDX_BITS'(d)) begin
          size_r[d] <= cfg_data[DIM_BITS-1:0];
        end
      end
    end
  end

  // Ranks clamped to the supported maximum.
  assign rank_eff = ({1'b0, rank_r} > RW'(MAX_RANK)) ? RW'(MAX_RANK) : {1'b0, rank_r};
  assign tr_eff   = ({1'b0, in_target_rank} > RW'(MAX_RANK)) ?
                    RW'(MAX_RANK) : {1'b0, in_target_rank};

  // The whole pipeline advances unless a finished beat is held at the output.
  assign en       = !ctl_s[NS].vld || !out_stall;
  assign in_stall = !en;

  // Entry: error check and right alignment of the target coordinates.
  always_comb begin
    logic          zero_any;
    logic [RW-1:0] t;
    logic [DIM_BITS-1:0] sel;
    zero_any = 1'b0;
    idx_al   = '0;
    t        = '0;
    sel      = '0;
    for (int d = 0; d < MAX_RANK; d++) begin
      if (RW'(d) < rank_eff && size_r[d] == '0) begin
        zero_any = 1'b1;
      end
      t   = RW'(d) + tr_eff - rank_eff;
      sel = '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        if (t == RW'(k)) begin
          sel = idx_in[k];
        end
      end
      if (RW'(d) < rank_eff && size_r[d] != DIM_BITS'(1)) begin
        idx_al[d*DIM_BITS +: DIM_BITS] = sel;
      end
    end
    ctl_nxt.vld = in_valid;
    ctl_nxt.req = in_req_type;
    if (in_req_type == REQ_SPLIT) begin
      ctl_nxt.err = zero_any ? ERR_ZERO_DIM : ERR_OK;
    end else begin
      ctl_nxt.err = (tr_eff < rank_eff) ? ERR_RANK : ERR_OK;
    end
  end

  // Entry registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s[0] <= '0;
    end else if (en) begin
      ctl_s[0] <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_s[0]   <= in_linear_index;
      rem_s[0] <= '0;
      acc_s[0] <= '0;
      crd_s[0] <= '0;
      idx_s[0] <= idx_al;
    end
  end

  // Divider stages, innermost dimension first; inactive dimensions divide by 1.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int DivDim = MAX_RANK - 1 - s / SPD;
    localparam bit HEn    = (s < MAX_RANK);
    localparam int HDim   = (s < MAX_RANK) ? s : 0;
    logic [DIM_BITS-1:0] div_w;

    assign div_w = (RW'(DivDim) < rank_eff) ? size_r[DivDim] : DIM_BITS'(1);

    tic_div_stage #(
      .DIM_BITS (DIM_BITS),
      .DIV_DIM  (DivDim),
      .FIRST    ((s % SPD) == 0),
      .LAST     ((s % SPD) == SPD - 1),
      .H_EN     (HEn),
      .H_DIM    (HDim)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_i   (ctl_s[s]),
      .q_i     (q_s[s]),
      .rem_i   (rem_s[s]),
      .acc_i   (acc_s[s]),
      .crd_i   (crd_s[s]),
      .idx_i   (idx_s[s]),
      .div_i   (div_w),
      .hsize_i (size_r[HDim]),
      .hact_i  (RW'(HDim) < rank_eff),
      .ctl_o   (ctl_s[s+1]),
      .q_o     (q_s[s+1]),
      .rem_o   (rem_s[s+1]),
      .acc_o   (acc_s[s+1]),
      .crd_o   (crd_s[s+1]),
      .idx_o   (idx_s[s+1])
    );
  end

  // Result formatting from the last stage.
  assign crd_ok            = (ctl_s[NS].req == REQ_SPLIT) && (ctl_s[NS].err == ERR_OK);
  assign out_valid         = ctl_s[NS].vld;
  assign out_error_code    = ctl_s[NS].err;
  assign out_linear_offset = (ctl_s[NS].req == REQ_OFFSET && ctl_s[NS].err == ERR_OK) ?
                             acc_s[NS] : '0;
  assign out_coord_0 = crd_ok ? crd_s[NS][0*DIM_BITS +: DIM_BITS] : '0;
  assign out_coord_1 = crd_ok ? crd_s[NS][1*DIM_BITS +: DIM_BITS] : '0;
  assign out_coord_2 = crd_ok ? crd_s[NS][2*DIM_BITS +: DIM_BITS] : '0;
  assign out_coord_3 = crd_ok ? crd_s[NS][3*DIM_BITS +: DIM_BITS] : '0;

  // Assertions.
  `TIC_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "input stalled without output stall")
  `TIC_ASSERT_NOW(a_err_zero, out_valid && out_error_code != ERR_OK, out_linear_offset == '0 && out_coord_0 == '0 && out_coord_3 == '0, "error beat carries data")
  `TIC_ASSERT_NOW(a_split_ofs, out_valid && ctl_s[NS].req == REQ_SPLIT, out_linear_offset == '0, "split beat carries an offset")
  `TIC_ASSERT_NEXT(a_advance, en, ctl_s[NS].vld == $past(ctl_s[NS-1].vld), "pipeline lost or repeated a beat")

endmodule

`default_nettype wire
